[rtl/core/cse_pkg.sv]
// Shared types, constants and micro-op table for the cubic spline evaluator.
// Used by cse_alu and cubic_spline_evaluate_top; depends on nothing.
`default_nettype none
package cse_pkg;

  localparam int KNOT_DEPTH = 1024;
  localparam int KIDX_W     = $clog2(KNOT_DEPTH);
  localparam int KCNT_W     = KIDX_W + 1;
  localparam int DW         = 32;
  localparam int XW         = 64;
  localparam int PC_W       = 6;

  localparam logic [KCNT_W-1:0] KCNT_MIN = KCNT_W'(2);
  localparam logic [KCNT_W-1:0] KCNT_MAX = KCNT_W'(KNOT_DEPTH);
  localparam logic [PC_W-1:0]   UOP_LAST = PC_W'(39);

  localparam logic [XW-1:0] SMAX = {1'b0, {(XW-1){1'b1}}};

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL16 = 3'd2,
    OP_MUL32 = 3'd3,
    OP_DIV16 = 3'd4,
    OP_DIV32 = 3'd5
  } alu_op_t;

  // codes below SR_Q are register-file entries, the rest are held inputs and constants
  typedef enum logic [4:0] {
    SR_DS    = 5'd0,
    SR_U     = 5'd1,
    SR_DX    = 5'd2,
    SR_CX1   = 5'd3,
    SR_CX2   = 5'd4,
    SR_T     = 5'd5,
    SR_T2    = 5'd6,
    SR_A     = 5'd7,
    SR_B     = 5'd8,
    SR_N     = 5'd9,
    SR_VAL   = 5'd10,
    SR_D1    = 5'd11,
    SR_D2    = 5'd12,
    SR_Q     = 5'd16,
    SR_S0    = 5'd17,
    SR_S1    = 5'd18,
    SR_X0    = 5'd19,
    SR_X1    = 5'd20,
    SR_M0    = 5'd21,
    SR_M1    = 5'd22,
    SR_ONE   = 5'd23,
    SR_TWO   = 5'd24,
    SR_THREE = 5'd25,
    SR_FOUR  = 5'd26,
    SR_SIX   = 5'd27
  } src_t;

  typedef struct packed {
    alu_op_t op;
    src_t    dst;
    src_t    srca;
    src_t    srcb;
  } uop_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic sat;
  } alu_rsp_t;

  function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = '{OP_SUB,   SR_DS,  SR_S1,  SR_S0};
      6'd1:  u = '{OP_SUB,   SR_U,   SR_Q,   SR_S0};
      6'd2:  u = '{OP_SUB,   SR_DX,  SR_X1,  SR_X0};
      6'd3:  u = '{OP_MUL16, SR_A,   SR_DS,  SR_M0};
      6'd4:  u = '{OP_SUB,   SR_A,   SR_A,   SR_X1};
      6'd5:  u = '{OP_ADD,   SR_CX1, SR_A,   SR_X0};
      6'd6:  u = '{OP_MUL16, SR_B,   SR_DS,  SR_M1};
      6'd7:  u = '{OP_SUB,   SR_B,   SR_B,   SR_X1};
      6'd8:  u = '{OP_ADD,   SR_CX2, SR_B,   SR_X0};
      6'd9:  u = '{OP_DIV32, SR_T,   SR_U,   SR_DS};
      6'd10: u = '{OP_MUL32, SR_T2,  SR_T,   SR_T};
      6'd11: u = '{OP_SUB,   SR_A,   SR_ONE, SR_T};
      6'd12: u = '{OP_MUL32, SR_A,   SR_A,   SR_CX1};
      6'd13: u = '{OP_MUL32, SR_B,   SR_T,   SR_CX2};
      6'd14: u = '{OP_SUB,   SR_A,   SR_A,   SR_B};
      6'd15: u = '{OP_SUB,   SR_B,   SR_T,   SR_T2};
      6'd16: u = '{OP_MUL32, SR_A,   SR_B,   SR_A};
      6'd17: u = '{OP_MUL32, SR_B,   SR_T,   SR_DX};
      6'd18: u = '{OP_ADD,   SR_B,   SR_X0,  SR_B};
      6'd19: u = '{OP_ADD,   SR_VAL, SR_B,   SR_A};
      6'd20: u = '{OP_MUL32, SR_A,   SR_T,   SR_FOUR};
      6'd21: u = '{OP_SUB,   SR_A,   SR_ONE, SR_A};
      6'd22: u = '{OP_MUL32, SR_B,   SR_T2,  SR_THREE};
      6'd23: u = '{OP_ADD,   SR_A,   SR_A,   SR_B};
      6'd24: u = '{OP_MUL32, SR_A,   SR_A,   SR_CX1};
      6'd25: u = '{OP_ADD,   SR_N,   SR_DX,  SR_A};
      6'd26: u = '{OP_MUL32, SR_A,   SR_T,   SR_THREE};
      6'd27: u = '{OP_SUB,   SR_A,   SR_A,   SR_TWO};
      6'd28: u = '{OP_MUL32, SR_A,   SR_T,   SR_A};
      6'd29: u = '{OP_MUL32, SR_A,   SR_A,   SR_CX2};
      6'd30: u = '{OP_ADD,   SR_N,   SR_N,   SR_A};
      6'd31: u = '{OP_DIV16, SR_D1,  SR_N,   SR_DS};
      6'd32: u = '{OP_MUL32, SR_A,   SR_T,   SR_SIX};
      6'd33: u = '{OP_SUB,   SR_B,   SR_A,   SR_FOUR};
      6'd34: u = '{OP_MUL32, SR_B,   SR_B,   SR_CX1};
      6'd35: u = '{OP_SUB,   SR_A,   SR_A,   SR_TWO};
      6'd36: u = '{OP_MUL32, SR_A,   SR_A,   SR_CX2};
      6'd37: u = '{OP_ADD,   SR_A,   SR_B,   SR_A};
      6'd38: u = '{OP_DIV16, SR_A,   SR_A,   SR_DS};
      6'd39: u = '{OP_DIV16, SR_D2,  SR_A,   SR_DS};
      default: u = '{OP_ADD, SR_A,   SR_A,   SR_A};
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

[rtl/core/cse_alu.sv]
// Saturating 64-bit arithmetic unit: add, subtract, multiply with shift, divide.
// Multiply takes four 32x32 partial products; divide is restoring, one bit a cycle.
// Depends on cse_pkg.
`default_nettype none
module cse_alu (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cse_pkg::alu_req_t   req,
  input  wire logic [63:0]         opa,
  input  wire logic [63:0]         opb,
  output cse_pkg::alu_rsp_t        rsp,
  output logic [63:0]              res
);
  import cse_pkg::*;

  typedef enum logic [5:0] {
    A_IDLE = 6'b000001,
    A_ADD  = 6'b000010,
    A_MAG  = 6'b000100,
    A_MUL  = 6'b001000,
    A_DIV  = 6'b010000,
    A_END  = 6'b100000
  } ast_t;

  ast_t          st_r, st_nxt;
  alu_op_t       op_r;
  logic          neg_r, done_r, sat_r;
  logic [63:0]   a_r, b_r, ua_r, ub_r, rem_r, res_r;
  logic [127:0]  acc_r;
  logic [95:0]   dvd_r, quo_r;
  logic [6:0]    cnt_r;

  logic [64:0]   sum;
  logic [63:0]   ma, mb, pp, mres, mm;
  logic [127:0]  pp_ext;
  logic [64:0]   rr;
  logic          ovf, msat;

  always_comb begin
    ma = a_r[63] ? (64'd0 - a_r) : a_r;
    mb = b_r[63] ? (64'd0 - b_r) : b_r;
    if (op_r == OP_SUB) begin
      sum = {a_r[63], a_r} - {b_r[63], b_r};
    end else begin
      sum = {a_r[63], a_r} + {b_r[63], b_r};
    end
    case (cnt_r[1:0])
      2'd0:    pp = ua_r[31:0] * ub_r[31:0];
      2'd1:    pp = ua_r[31:0] * ub_r[63:32];
      2'd2:    pp = ua_r[63:32] * ub_r[31:0];
      default: pp = ua_r[63:32] * ub_r[63:32];
    endcase
    case (cnt_r[1:0])
      2'd0:    pp_ext = {64'd0, pp};
      2'd1,
      2'd2:    pp_ext = {32'd0, pp, 32'd0};
      default: pp_ext = {pp, 64'd0};
    endcase
    rr = {rem_r, dvd_r[95]};
    case (op_r)
      OP_MUL16: begin
        ovf  = |acc_r[127:80];
        mres = acc_r[79:16];
      end
      OP_MUL32: begin
        ovf  = |acc_r[127:96];
        mres = acc_r[95:32];
      end
      default: begin
        ovf  = |quo_r[95:63];
        mres = quo_r[63:0];
      end
    endcase
    msat = ovf | mres[63];
    mm   = msat ? SMAX : mres;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      A_IDLE: if (req.start) begin
        st_nxt = (req.op == OP_ADD || req.op == OP_SUB) ? A_ADD : A_MAG;
      end
      A_ADD:  st_nxt = A_IDLE;
      A_MAG:  st_nxt = (op_r == OP_MUL16 || op_r == OP_MUL32) ? A_MUL : A_DIV;
      A_MUL:  if (cnt_r[1:0] == 2'd3) st_nxt = A_END;
      A_DIV:  if (cnt_r == 7'd95) st_nxt = A_END;
      A_END:  st_nxt = A_IDLE;
      default: st_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= A_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == A_ADD) || (st_r == A_END);
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      A_IDLE: if (req.start) begin
        a_r   <= opa;
        b_r   <= opb;
        op_r  <= req.op;
        neg_r <= opa[63] ^ opb[63];
      end
      A_ADD: begin
        if ($signed(sum) > $signed({1'b0, SMAX})) begin
          res_r <= SMAX;
          sat_r <= 1'b1;
        end else if ($signed(sum) < -$signed({1'b0, SMAX})) begin
          res_r <= 64'd0 - SMAX;
          sat_r <= 1'b1;
        end else begin
          res_r <= sum[63:0];
          sat_r <= 1'b0;
        end
      end
      A_MAG: begin
        ua_r  <= ma;
        ub_r  <= mb;
        acc_r <= '0;
        rem_r <= '0;
        quo_r <= '0;
        cnt_r <= '0;
        dvd_r <= (op_r == OP_DIV32) ? {ma, 32'd0} : {16'd0, ma, 16'd0};
      end
      A_MUL: begin
        acc_r <= acc_r + pp_ext;
        cnt_r <= cnt_r + 7'd1;
      end
      A_DIV: begin
        if (rr >= {1'b0, ub_r}) begin
          rem_r <= 64'(rr - {1'b0, ub_r});
          quo_r <= {quo_r[94:0], 1'b1};
        end else begin
          rem_r <= rr[63:0];
          quo_r <= {quo_r[94:0], 1'b0};
        end
        dvd_r <= {dvd_r[94:0], 1'b0};
        cnt_r <= cnt_r + 7'd1;
      end
      A_END: begin
        res_r <= neg_r ? (64'd0 - mm) : mm;
        sat_r <= msat;
      end
      default: ;
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.sat  = sat_r;
  assign res      = res_r;

endmodule
`default_nettype wire

[rtl/core/cubic_spline_evaluate_top.sv]
// Top level of the cubic Hermite spline evaluator: knot memory, segment search,
// micro-op sequencer over a two-read register file. Depends on cse_pkg, cse_alu.
`default_nettype none
//  channel   direction  handshake             payload
//  in_*      slave      tvalid/tready         tuser = mode, tdata = knot and query fields
//  out_*     master     tvalid/tready         tdata = value, first, second, status
//  cfg_*     slave      APB psel/penable      knot_count at byte address 0
//
//  A load is written as it is accepted. A query runs up to ten search steps, each a
//  read state and a compare state, two knot reads, then up to 40 micro-ops; the
//  bit-serial divider (four 96-step divisions) takes most of a query's time.
//  Reset is synchronous; the knot memory is not cleared, knot_count resets to 2.
//  A finished result waits in the output register while the next item is taken;
//  the sequencer stalls at its last step only if that register is still full.
module cubic_spline_evaluate_top (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [143:0]  in_tdata,  // knot_index, knot_pos, knot_value, knot_slope, query_pos
  input  wire logic          in_tuser,  // mode
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [103:0]       out_tdata, // value_out, first_deriv, second_deriv, status
  input  wire logic          cfg_psel,
  input  wire logic          cfg_penable,
  input  wire logic          cfg_pwrite,
  input  wire logic [2:0]    cfg_paddr,
  input  wire logic [31:0]   cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import cse_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_SRD  = 10'b0000000010,
    S_SCMP = 10'b0000000100,
    S_LRD  = 10'b0000001000,
    S_HRD  = 10'b0000010000,
    S_HCAP = 10'b0000100000,
    S_URD  = 10'b0001000000,
    S_UGO  = 10'b0010000000,
    S_UWT  = 10'b0100000000,
    S_FIN  = 10'b1000000000
  } st_t;

  st_t                st_r, st_nxt;
  logic [KCNT_W-1:0]  kc_r, kc_eff;
  logic [KIDX_W-1:0]  lo_r, hi_r, mid, kc_hi, kmem_ra;
  logic [KCNT_W-1:0]  mid_sum;
  logic [95:0]        kmem [KNOT_DEPTH];
  logic [95:0]        kmem_rd_r;
  logic [DW-1:0]      q_r, s0_r, s1_r, x0_r, x1_r, m0_r, m1_r;
  logic [PC_W-1:0]    pc_r;
  uop_t               uop;
  logic [XW-1:0]      rf_mem [16];
  logic [XW-1:0]      rf_a_r, rf_b_r, opa, opb, alu_res;
  logic               sat_r, sat_nxt, in_acc, q_less, last_ok;
  logic [DW-1:0]      wval_r, wd1_r, wd2_r, oval_r, od1_r, od2_r;
  logic [1:0]         wst_r, ost_r;
  logic               out_vld_r, slot_free;
  logic [DW:0]        cl;
  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;

  function automatic logic [XW-1:0] sel_op(input src_t s, input logic [XW-1:0] rf_d,
                                           input logic [DW-1:0] q, input logic [DW-1:0] s0,
                                           input logic [DW-1:0] s1, input logic [DW-1:0] x0,
                                           input logic [DW-1:0] x1, input logic [DW-1:0] m0,
                                           input logic [DW-1:0] m1);
    logic [XW-1:0] r;
    case (s)
      SR_Q:     r = {{(XW-DW){q[DW-1]}}, q};
      SR_S0:    r = {{(XW-DW){s0[DW-1]}}, s0};
      SR_S1:    r = {{(XW-DW){s1[DW-1]}}, s1};
      SR_X0:    r = {{(XW-DW){x0[DW-1]}}, x0};
      SR_X1:    r = {{(XW-DW){x1[DW-1]}}, x1};
      SR_M0:    r = {{(XW-DW){m0[DW-1]}}, m0};
      SR_M1:    r = {{(XW-DW){m1[DW-1]}}, m1};
      SR_ONE:   r = 64'h0000_0001_0000_0000;
      SR_TWO:   r = 64'h0000_0002_0000_0000;
      SR_THREE: r = 64'h0000_0003_0000_0000;
      SR_FOUR:  r = 64'h0000_0004_0000_0000;
      SR_SIX:   r = 64'h0000_0006_0000_0000;
      default:  r = rf_d;
    endcase
    return r;
  endfunction

  // {saturated, value clamped to the signed output range}
  function automatic logic [DW:0] clamp_out(input logic [XW-1:0] v);
    logic [DW:0] r;
    if ($signed(v) > $signed({{(XW-DW+1){1'b0}}, {(DW-1){1'b1}}})) begin
      r = {1'b1, 1'b0, {(DW-1){1'b1}}};
    end else if ($signed(v) < $signed({{(XW-DW+1){1'b1}}, {(DW-1){1'b0}}})) begin
      r = {1'b1, 1'b1, {(DW-1){1'b0}}};
    end else begin
      r = {1'b0, v[DW-1:0]};
    end
    return r;
  endfunction

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {{(32-KCNT_W){1'b0}}, kc_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kc_r <= KCNT_MIN;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == 1'b0) begin
      kc_r <= cfg_pwdata[KCNT_W-1:0];
    end
  end

  always_comb begin
    if (kc_r < KCNT_MIN) begin
      kc_eff = KCNT_MIN;
    end else if (kc_r > KCNT_MAX) begin
      kc_eff = KCNT_MAX;
    end else begin
      kc_eff = kc_r;
    end
  end
  assign kc_hi = KIDX_W'(kc_eff - KCNT_W'(1));

  // search and micro-op control
  assign in_tready = (st_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid       = mid_sum[KCNT_W-1:1];
  assign q_less    = $signed(q_r) < $signed(kmem_rd_r[DW-1:0]);
  assign uop       = uop_rom(pc_r);
  assign opa       = sel_op(uop.srca, rf_a_r, q_r, s0_r, s1_r, x0_r, x1_r, m0_r, m1_r);
  assign opb       = sel_op(uop.srcb, rf_b_r, q_r, s0_r, s1_r, x0_r, x1_r, m0_r, m1_r);
  assign cl        = clamp_out(alu_res);
  assign slot_free = !out_vld_r || out_tready;
  assign last_ok   = 1'b1;

  always_comb begin
    case (st_r)
      S_LRD:   kmem_ra = hi_r - KIDX_W'(1);
      S_HRD:   kmem_ra = hi_r;
      default: kmem_ra = mid;
    endcase
  end

  always_comb begin
    sat_nxt = sat_r | alu_rsp.sat;
    if (uop.dst == SR_VAL || uop.dst == SR_D1 || uop.dst == SR_D2) begin
      sat_nxt = sat_nxt | cl[DW];
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (in_acc && in_tuser) begin
        st_nxt = (kc_hi > KIDX_W'(1)) ? S_SRD : S_LRD;
      end
      S_SRD:  st_nxt = S_SCMP;
      S_SCMP: begin
        if (q_less) begin
          st_nxt = (mid - lo_r > KIDX_W'(1)) ? S_SRD : S_LRD;
        end else begin
          st_nxt = (hi_r - mid > KIDX_W'(1)) ? S_SRD : S_LRD;
        end
      end
      S_LRD:  st_nxt = S_HRD;
      S_HRD:  st_nxt = S_HCAP;
      S_HCAP: st_nxt = S_URD;
      S_URD:  st_nxt = S_UGO;
      S_UGO:  st_nxt = S_UWT;
      S_UWT: if (alu_rsp.done) begin
        if ((pc_r == '0 && alu_res == '0) || pc_r == UOP_LAST) begin
          st_nxt = S_FIN;
        end else begin
          st_nxt = S_URD;
        end
      end
      S_FIN:  if (slot_free && last_ok) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_FIN && slot_free) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // knot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (in_acc && !in_tuser) begin
      kmem[in_tdata[KIDX_W-1:0]] <= in_tdata[105:10];
    end
    kmem_rd_r <= kmem[kmem_ra];
  end

  // register file: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (st_r == S_UWT && alu_rsp.done) begin
      rf_mem[uop.dst[3:0]] <= alu_res;
    end
    rf_a_r <= rf_mem[uop.srca[3:0]];
    rf_b_r <= rf_mem[uop.srcb[3:0]];
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      S_IDLE: if (in_acc && in_tuser) begin
        q_r  <= in_tdata[137:106];
        lo_r <= '0;
        hi_r <= kc_hi;
      end
      S_SCMP: begin
        if (q_less) begin
          hi_r <= mid;
        end else begin
          lo_r <= mid;
        end
      end
      S_HRD: begin
        s0_r <= kmem_rd_r[31:0];
        x0_r <= kmem_rd_r[63:32];
        m0_r <= kmem_rd_r[95:64];
      end
      S_HCAP: begin
        s1_r  <= kmem_rd_r[31:0];
        x1_r  <= kmem_rd_r[63:32];
        m1_r  <= kmem_rd_r[95:64];
        pc_r  <= '0;
        sat_r <= 1'b0;
      end
      S_UWT: if (alu_rsp.done) begin
        sat_r <= sat_nxt;
        pc_r  <= pc_r + PC_W'(1);
        if (uop.dst == SR_VAL) wval_r <= cl[DW-1:0];
        if (uop.dst == SR_D1)  wd1_r  <= cl[DW-1:0];
        if (uop.dst == SR_D2)  wd2_r  <= cl[DW-1:0];
        if (pc_r == '0 && alu_res == '0) begin
          wval_r <= '0;
          wd1_r  <= '0;
          wd2_r  <= '0;
          wst_r  <= ST_ZERO;
        end else if (pc_r == UOP_LAST) begin
          wst_r <= sat_nxt ? ST_SAT : ST_OK;
        end
      end
      S_FIN: if (slot_free) begin
        oval_r <= wval_r;
        od1_r  <= wd1_r;
        od2_r  <= wd2_r;
        ost_r  <= wst_r;
      end
      default: ;
    endcase
  end

  assign alu_req.start = (st_r == S_UGO);
  assign alu_req.op    = uop.op;

  cse_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .opa   (opa),
    .opb   (opb),
    .rsp   (alu_rsp),
    .res   (alu_res)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, ost_r, od2_r, od1_r, oval_r};

endmodule
`default_nettype wire
